[rtl/cbb_pkg.sv]
`timescale 1ns / 1ps
// cbb_pkg: widths, pipeline latencies and the carried-payload type of the
// cubic Bezier bounding box. Depends on nothing.
package cbb_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_T    = 24;              // fraction bits of a root t
   localparam int ABC_W     = 36;              // signed a and b
   localparam int C_W       = 33;              // signed c
   localparam int MAG_W     = 35;              // magnitude of a and b
   localparam int D_W       = 70;              // discriminant magnitude
   localparam int SQRT_BITS = 60;
   localparam int REM_W     = 2 * SQRT_BITS;
   localparam int Q2_W      = 62;
   localparam int N1_W      = 61;
   localparam int DV1_W     = 36;
   localparam int N2_W      = 82;
   localparam int DV2_W     = 60;
   localparam int DIV_LAT   = FRAC_T + 1;
   localparam int EVAL_LAT  = 6;
   localparam int CARRY_LEN = 3 + SQRT_BITS + 2 + DIV_LAT + 1 + EVAL_LAT;
   localparam int AXIS_LAT  = CARRY_LEN + 1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type [3:0]         p;
      coord_type               lo;
      coord_type               hi;
      logic                    cubic;
      logic signed [ABC_W-1:0] a;
      logic signed [ABC_W-1:0] b;
      logic signed [C_W-1:0]   c;
   } carry_type;

endpackage

[rtl/cbb_div.sv]
`timescale 1ns / 1ps
// cbb_div: pipelined restoring divider, one quotient bit per stage.
// Flags quotients that do not fit QUO_W bits. Uses cbb_pkg.
module cbb_div #(
   parameter int NUM_W = cbb_pkg::N1_W,
   parameter int DEN_W = cbb_pkg::DV1_W,
   parameter int QUO_W = cbb_pkg::FRAC_T
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic             en,
   output logic [QUO_W-1:0] quo,
   output logic             ok
);

   localparam int RW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [RW-1:0]    rem_ff [QUO_W+1];
   logic [RW-1:0]    den_ff [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             ok_ff  [QUO_W+1];
   logic [RW-1:0]    num_ext;
   logic [RW-1:0]    den_ext;

   assign num_ext = {{(RW-NUM_W){1'b0}}, num};
   assign den_ext = {{(RW-DEN_W){1'b0}}, den};

   // drop the item when the quotient would reach 2^QUO_W
   always_ff @(posedge clock) begin
      rem_ff[0] <= num_ext;
      den_ff[0] <= den_ext;
      q_ff[0]   <= '0;
      ok_ff[0]  <= en && (num_ext < (den_ext << QUO_W));
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      localparam int BIT = QUO_W - k;
      logic [RW-1:0] trial;
      assign trial = den_ff[k-1] << BIT;
      always_ff @(posedge clock) begin
         den_ff[k] <= den_ff[k-1];
         ok_ff[k]  <= ok_ff[k-1];
         if (rem_ff[k-1] >= trial) begin
            rem_ff[k] <= rem_ff[k-1] - trial;
            q_ff[k]   <= q_ff[k-1] | (QUO_W'(1) << BIT);
         end else begin
            rem_ff[k] <= rem_ff[k-1];
            q_ff[k]   <= q_ff[k-1];
         end
      end
   end

   assign quo = q_ff[QUO_W];
   assign ok  = ok_ff[QUO_W];

endmodule

[rtl/cbb_eval.sv]
`timescale 1ns / 1ps
// cbb_eval: exact de Casteljau value of one cubic axis at t / 2^24, truncated
// toward zero to Q16.16, in six register stages. Uses cbb_pkg.
module cbb_eval (
   input  logic                          clock,
   input  cbb_pkg::coord_type [3:0]      p,
   input  logic [cbb_pkg::FRAC_T-1:0]    t,
   input  logic [cbb_pkg::FRAC_T:0]      u,
   input  logic                          ok,
   output cbb_pkg::coord_type            val,
   output logic                          val_ok
);

   localparam int XW = cbb_pkg::FRAC_T + 1;
   localparam int RW = cbb_pkg::COORD_W + cbb_pkg::FRAC_T;   // 56
   localparam int SW = RW + cbb_pkg::FRAC_T;                 // 80
   localparam int VW = SW + cbb_pkg::FRAC_T;                 // 104

   logic [31:0]      qv [4];
   logic [RW:0]      r_sum [3];
   logic [RW-1:0]    r_ff [3];
   logic [XW-1:0]    uu_ff [3];
   logic [XW-1:0]    tt_ff [3];
   logic             ok_ff [cbb_pkg::EVAL_LAT];
   logic [RW-1:0]    rr [4];
   logic [XW-1:0]    xx [4];
   logic [56:0]      lo_ff [4];
   logic [48:0]      hi_ff [4];
   logic [SW+1:0]    s_sum [2];
   logic [SW-1:0]    s_ff [2];
   logic [XW-1:0]    sx [2];
   logic [56:0]      pl_ff [2];
   logic [56:0]      pm_ff [2];
   logic [40:0]      pt_ff [2];
   logic [VW+1:0]    v_sum;
   logic [VW-1:0]    v_ff;
   logic [31:0]      fl;
   logic             fr;
   cbb_pkg::coord_type sv;
   cbb_pkg::coord_type val_ff;

   // E1: first de Casteljau level
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qv[i] = p[i] ^ 32'h8000_0000;
      end
      for (int i = 0; i < 3; i++) begin
         r_sum[i] = qv[i] * u + qv[i+1] * {1'b0, t};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         r_ff[i] <= r_sum[i][RW-1:0];
      end
      uu_ff[0] <= u;
      tt_ff[0] <= {1'b0, t};
      for (int i = 1; i < 3; i++) begin
         uu_ff[i] <= uu_ff[i-1];
         tt_ff[i] <= tt_ff[i-1];
      end
      ok_ff[0] <= ok;
      for (int i = 1; i < cbb_pkg::EVAL_LAT; i++) begin
         ok_ff[i] <= ok_ff[i-1];
      end
   end

   // E2: split the second level products into 32-bit halves
   always_comb begin
      rr[0] = r_ff[0]; xx[0] = uu_ff[0];
      rr[1] = r_ff[1]; xx[1] = tt_ff[0];
      rr[2] = r_ff[1]; xx[2] = uu_ff[0];
      rr[3] = r_ff[2]; xx[3] = tt_ff[0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         lo_ff[i] <= rr[i][31:0] * xx[i];
         hi_ff[i] <= rr[i][RW-1:32] * xx[i];
      end
   end

   // E3: second level sums
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         s_sum[j] = {hi_ff[2*j], 32'b0} + lo_ff[2*j] + {hi_ff[2*j+1], 32'b0}
                    + lo_ff[2*j+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         s_ff[j] <= s_sum[j][SW-1:0];
      end
   end

   // E4: third level partial products
   assign sx[0] = uu_ff[2];
   assign sx[1] = tt_ff[2];

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         pl_ff[j] <= s_ff[j][31:0] * sx[j];
         pm_ff[j] <= s_ff[j][63:32] * sx[j];
         pt_ff[j] <= s_ff[j][SW-1:64] * sx[j];
      end
   end

   // E5: full value, scaled by 2^72
   assign v_sum = pl_ff[0] + {pm_ff[0], 32'b0} + {pt_ff[0], 64'b0}
                + pl_ff[1] + {pm_ff[1], 32'b0} + {pt_ff[1], 64'b0};

   always_ff @(posedge clock) begin
      v_ff <= v_sum[VW-1:0];
   end

   // E6: remove the offset and truncate toward zero
   assign fl = v_ff[VW-1:VW-32];
   assign fr = |v_ff[VW-33:0];
   assign sv = signed'(fl ^ 32'h8000_0000);

   always_ff @(posedge clock) begin
      if (sv[cbb_pkg::COORD_W-1] && fr) begin
         val_ff <= sv + cbb_pkg::coord_type'(1);
      end else begin
         val_ff <= sv;
      end
   end

   assign val    = val_ff;
   assign val_ok = ok_ff[cbb_pkg::EVAL_LAT-1];

endmodule

[rtl/cubic_bezier_bounding_box.sv]
`timescale 1ns / 1ps
// cubic_bezier_bounding_box: tight axis-aligned box of a line or cubic Bezier.
// Uses cbb_pkg, cbb_div and cbb_eval.
//
// Usage: drive the segment on the req_ ports and raise start; the item is
// taken at the rising edge where start is high and busy is low. busy is high
// only while reset is held, so a new item may be started in every cycle.
// Each item produces one box on the rsp_ ports, marked by rsp_valid for one
// cycle; results leave in order. Throughput is one item per clock. Each
// item passes through the per-axis chain: discriminant (3 stages), a
// 60-stage square root, root setup (2), a 25-stage restoring divider, the
// root range check (1), a 6-stage curve evaluator and the final min/max
// stage.
// The two axes run side by side, each with two dividers and two evaluators.
// The receiver cannot stall, so nothing inside ever holds.
// Synchronous reset clears all valid bits; items in flight are dropped and
// no rsp_valid is raised until new items arrive.
module cubic_bezier_bounding_box (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_is_cubic,
   input  cbb_pkg::coord_type  req_p0_x,
   input  cbb_pkg::coord_type  req_p0_y,
   input  cbb_pkg::coord_type  req_p1_x,
   input  cbb_pkg::coord_type  req_p1_y,
   input  cbb_pkg::coord_type  req_p2_x,
   input  cbb_pkg::coord_type  req_p2_y,
   input  cbb_pkg::coord_type  req_p3_x,
   input  cbb_pkg::coord_type  req_p3_y,
   output logic                rsp_valid,
   output cbb_pkg::coord_type  rsp_box_min_x,
   output cbb_pkg::coord_type  rsp_box_min_y,
   output cbb_pkg::coord_type  rsp_box_max_x,
   output cbb_pkg::coord_type  rsp_box_max_y
);

   localparam int ABC_W = cbb_pkg::ABC_W;
   localparam int C_W   = cbb_pkg::C_W;
   localparam int MAG_W = cbb_pkg::MAG_W;
   localparam int CW    = cbb_pkg::COORD_W;
   localparam int FT    = cbb_pkg::FRAC_T;
   localparam int SB    = cbb_pkg::SQRT_BITS;
   localparam int IX_A4 = 3 + SB;
   localparam int IX_DV = IX_A4 + 1 + cbb_pkg::DIV_LAT;
   localparam int IX_A6 = IX_DV + 1;
   localparam int IX_EV = IX_A6 + cbb_pkg::EVAL_LAT;

   logic               in_vld_ff;
   logic               cub_ff;
   cbb_pkg::coord_type pt_ff [2][4];
   logic               vld_ff [cbb_pkg::AXIS_LAT];
   cbb_pkg::coord_type box_lo [2];
   cbb_pkg::coord_type box_hi [2];

   function automatic logic [MAG_W-1:0] mag_ab(input logic signed [ABC_W-1:0] v);
      logic signed [ABC_W-1:0] n;
      n = v[ABC_W-1] ? -v : v;
      return n[MAG_W-1:0];
   endfunction

   function automatic logic [C_W-1:0] mag_c(input logic signed [C_W-1:0] v);
      logic signed [C_W-1:0] n;
      n = v[C_W-1] ? -v : v;
      return n;
   endfunction

   assign busy = reset;

   // input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      cub_ff      <= req_is_cubic;
      pt_ff[0][0] <= req_p0_x;
      pt_ff[0][1] <= req_p1_x;
      pt_ff[0][2] <= req_p2_x;
      pt_ff[0][3] <= req_p3_x;
      pt_ff[1][0] <= req_p0_y;
      pt_ff[1][1] <= req_p1_y;
      pt_ff[1][2] <= req_p2_y;
      pt_ff[1][3] <= req_p3_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < cbb_pkg::AXIS_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld_ff;
         for (int k = 1; k < cbb_pkg::AXIS_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_axis
      cbb_pkg::carry_type          c_ff [cbb_pkg::CARRY_LEN];
      cbb_pkg::carry_type          c_in;
      logic signed [ABC_W-1:0]     e [4];
      // discriminant
      logic [cbb_pkg::D_W-1:0]     bb_ff;
      logic [MAG_W+C_W-1:0]        ac_ff;
      logic [cbb_pkg::D_W-1:0]     ac4;
      logic [cbb_pkg::D_W-1:0]     d_ff;
      logic                        dneg_ff;
      logic                        opp;
      // square root
      logic [cbb_pkg::REM_W-1:0]   rem_ff  [SB];
      logic [SB-1:0]               root_ff [SB];
      logic                        sneg_ff [SB];
      // root setup
      cbb_pkg::carry_type          c4;
      cbb_pkg::carry_type          c5;
      logic signed [cbb_pkg::Q2_W-1:0] bsh, sr, q2_in, q2_ff, mq2;
      logic                        neg4_ff;
      logic                        az, bz, cz, q2z;
      logic [MAG_W-1:0]            ma5, mb5;
      logic [C_W-1:0]              mc5;
      logic [cbb_pkg::N1_W-1:0]    n1_ff;
      logic [cbb_pkg::DV1_W-1:0]   dv1_ff;
      logic [cbb_pkg::N2_W-1:0]    n2_ff;
      logic [cbb_pkg::DV2_W-1:0]   dv2_ff;
      logic                        en1_ff, en2_ff;
      // divider results and evaluation
      logic [FT-1:0]               dq [2];
      logic                        dok [2];
      logic [FT-1:0]               t6_ff [2];
      logic [FT:0]                 u6_ff [2];
      logic                        ok6_ff [2];
      cbb_pkg::coord_type          ev [2];
      logic                        ev_ok [2];
      cbb_pkg::coord_type          lo1, hi1, lo2, hi2;
      cbb_pkg::coord_type          lo_ff, hi_ff;
      cbb_pkg::carry_type          c7;

      // A1: polynomial coefficients and endpoint box
      always_comb begin
         for (int i = 0; i < 4; i++) begin
            e[i] = {{(ABC_W-CW){pt_ff[g][i][CW-1]}}, pt_ff[g][i]};
         end
         for (int i = 0; i < 4; i++) begin
            c_in.p[i] = pt_ff[g][i];
         end
         c_in.cubic = cub_ff;
         c_in.a     = -e[0] + 3 * e[1] - 3 * e[2] + e[3];
         c_in.b     = (e[0] - (e[1] <<< 1) + e[2]) <<< 1;
         c_in.c     = {pt_ff[g][1][CW-1], pt_ff[g][1]} - {pt_ff[g][0][CW-1], pt_ff[g][0]};
         if (pt_ff[g][0] < pt_ff[g][3]) begin
            c_in.lo = pt_ff[g][0];
            c_in.hi = pt_ff[g][3];
         end else begin
            c_in.lo = pt_ff[g][3];
            c_in.hi = pt_ff[g][0];
         end
      end

      always_ff @(posedge clock) begin
         c_ff[0] <= c_in;
         for (int k = 1; k < cbb_pkg::CARRY_LEN; k++) begin
            c_ff[k] <= c_ff[k-1];
         end
      end

      // A2: b^2 and |a||c|
      always_ff @(posedge clock) begin
         bb_ff <= mag_ab(c_ff[0].b) * mag_ab(c_ff[0].b);
         ac_ff <= mag_ab(c_ff[0].a) * mag_c(c_ff[0].c);
      end

      // A3: D = b^2 - 4ac, kept as magnitude with a negative flag
      assign ac4 = {ac_ff, 2'b00};
      assign opp = (c_ff[1].c != '0) && (c_ff[1].a[ABC_W-1] != c_ff[1].c[C_W-1]);

      always_ff @(posedge clock) begin
         if (opp) begin
            d_ff    <= bb_ff + ac4;
            dneg_ff <= 1'b0;
         end else begin
            d_ff    <= bb_ff - ac4;
            dneg_ff <= ac4 > bb_ff;
         end
      end

      // square root of D * 2^48, one result bit per stage
      for (genvar k = 0; k < SB; k++) begin : g_sqrt
         localparam int BIT = SB - 1 - k;
         logic [cbb_pkg::REM_W-1:0] rin;
         logic [cbb_pkg::REM_W-1:0] trial;
         logic [SB-1:0]             qin;
         logic                      nin;
         if (k == 0) begin : g_first
            assign rin = cbb_pkg::REM_W'(d_ff) << (2 * FT);
            assign qin = '0;
            assign nin = dneg_ff;
         end else begin : g_next
            assign rin = rem_ff[k-1];
            assign qin = root_ff[k-1];
            assign nin = sneg_ff[k-1];
         end
         assign trial = (cbb_pkg::REM_W'(qin) << (BIT + 1))
                      | (cbb_pkg::REM_W'(1) << (2 * BIT));
         always_ff @(posedge clock) begin
            sneg_ff[k] <= nin;
            if (rin >= trial) begin
               rem_ff[k]  <= rin - trial;
               root_ff[k] <= qin | (SB'(1) << BIT);
            end else begin
               rem_ff[k]  <= rin;
               root_ff[k] <= qin;
            end
         end
      end

      // A4: 2q = -(b*2^24 + sign(b)*sqrt)
      assign c4  = c_ff[IX_A4-1];
      assign bsh = {{(cbb_pkg::Q2_W-ABC_W-FT){c4.b[ABC_W-1]}}, c4.b, {FT{1'b0}}};
      assign sr  = {{(cbb_pkg::Q2_W-SB){1'b0}}, root_ff[SB-1]};
      assign q2_in = c4.b[ABC_W-1] ? (sr - bsh) : -(bsh + sr);

      always_ff @(posedge clock) begin
         q2_ff   <= q2_in;
         neg4_ff <= sneg_ff[SB-1];
      end

      // A5: select the divisions and their enables
      assign c5  = c_ff[IX_A4];
      assign az  = c5.a == '0;
      assign bz  = c5.b == '0;
      assign cz  = c5.c == '0;
      assign q2z = q2_ff == '0;
      assign mq2 = q2_ff[cbb_pkg::Q2_W-1] ? -q2_ff : q2_ff;
      assign ma5 = mag_ab(c5.a);
      assign mb5 = mag_ab(c5.b);
      assign mc5 = mag_c(c5.c);

      always_ff @(posedge clock) begin
         if (az) begin
            n1_ff  <= {{(cbb_pkg::N1_W-C_W-FT){1'b0}}, mc5, {FT{1'b0}}};
            dv1_ff <= {{(cbb_pkg::DV1_W-MAG_W){1'b0}}, mb5};
            en1_ff <= c5.cubic && !bz && !cz && (c5.c[C_W-1] != c5.b[ABC_W-1]);
         end else begin
            n1_ff  <= mq2[cbb_pkg::N1_W-1:0];
            dv1_ff <= {ma5, 1'b0};
            en1_ff <= c5.cubic && !neg4_ff && !q2z
                      && (q2_ff[cbb_pkg::Q2_W-1] == c5.a[ABC_W-1]);
         end
         n2_ff  <= {mc5, {(cbb_pkg::N2_W-C_W){1'b0}}};
         dv2_ff <= mq2[cbb_pkg::DV2_W-1:0];
         en2_ff <= c5.cubic && !az && !neg4_ff && !q2z && !cz
                   && (c5.c[C_W-1] == q2_ff[cbb_pkg::Q2_W-1]);
      end

      cbb_div #(
         .NUM_W (cbb_pkg::N1_W),
         .DEN_W (cbb_pkg::DV1_W),
         .QUO_W (FT)
      ) u_div_near (
         .clock (clock),
         .num   (n1_ff),
         .den   (dv1_ff),
         .en    (en1_ff),
         .quo   (dq[0]),
         .ok    (dok[0])
      );

      cbb_div #(
         .NUM_W (cbb_pkg::N2_W),
         .DEN_W (cbb_pkg::DV2_W),
         .QUO_W (FT)
      ) u_div_far (
         .clock (clock),
         .num   (n2_ff),
         .den   (dv2_ff),
         .en    (en2_ff),
         .quo   (dq[1]),
         .ok    (dok[1])
      );

      // A6: keep only roots strictly inside (0,1)
      always_ff @(posedge clock) begin
         for (int j = 0; j < 2; j++) begin
            t6_ff[j]  <= dq[j];
            u6_ff[j]  <= {1'b1, {FT{1'b0}}} - {1'b0, dq[j]};
            ok6_ff[j] <= dok[j] && (dq[j] != '0);
         end
      end

      for (genvar j = 0; j < 2; j++) begin : g_eval
         cbb_eval u_eval (
            .clock  (clock),
            .p      (c_ff[IX_A6].p),
            .t      (t6_ff[j]),
            .u      (u6_ff[j]),
            .ok     (ok6_ff[j]),
            .val    (ev[j]),
            .val_ok (ev_ok[j])
         );
      end

      // A7: widen the endpoint box
      assign c7 = c_ff[IX_EV];

      always_comb begin
         lo1 = (ev_ok[0] && ev[0] < c7.lo) ? ev[0] : c7.lo;
         hi1 = (ev_ok[0] && ev[0] > c7.hi) ? ev[0] : c7.hi;
         lo2 = (ev_ok[1] && ev[1] < lo1) ? ev[1] : lo1;
         hi2 = (ev_ok[1] && ev[1] > hi1) ? ev[1] : hi1;
      end

      always_ff @(posedge clock) begin
         lo_ff <= lo2;
         hi_ff <= hi2;
      end

      assign box_lo[g] = lo_ff;
      assign box_hi[g] = hi_ff;
   end

   assign rsp_valid     = vld_ff[cbb_pkg::AXIS_LAT-1];
   assign rsp_box_min_x = box_lo[0];
   assign rsp_box_min_y = box_lo[1];
   assign rsp_box_max_x = box_hi[0];
   assign rsp_box_max_y = box_hi[1];

endmodule

[dv/cubic_bezier_bounding_box_tb.sv]
`timescale 1ns / 1ps
// Testbench for cubic_bezier_bounding_box: directed and random lines and cubics,
// boxes predicted in exact integer arithmetic and checked in order. Uses cbb_pkg.
module cubic_bezier_bounding_box_tb;

   localparam int ONE_T      = 1 << 24;
   localparam int DRAIN_CYC  = 150;
   localparam int STALL_CAP  = 2000;

   typedef struct {
      logic               cubic;
      cbb_pkg::coord_type px [4];
      cbb_pkg::coord_type py [4];
   } segment_type;

   typedef struct {
      cbb_pkg::coord_type min_x, min_y, max_x, max_y;
   } box_type;

   logic      clock, reset, busy;
   logic      start = 1'b0;
   logic      req_is_cubic = 1'b0;
   cbb_pkg::coord_type req_p0_x = '0, req_p0_y = '0, req_p1_x = '0, req_p1_y = '0;
   cbb_pkg::coord_type req_p2_x = '0, req_p2_y = '0, req_p3_x = '0, req_p3_y = '0;
   logic      rsp_valid;
   cbb_pkg::coord_type rsp_box_min_x, rsp_box_min_y, rsp_box_max_x, rsp_box_max_y;

   segment_type seg_queue [$];
   box_type     box_queue [$];
   int          idle_pct;
   int          errors = 0;
   int          quiet_cycles = 0;
   bit          timed_out = 1'b0;

   cubic_bezier_bounding_box u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_is_cubic(req_is_cubic),
      .req_p0_x(req_p0_x), .req_p0_y(req_p0_y), .req_p1_x(req_p1_x), .req_p1_y(req_p1_y),
      .req_p2_x(req_p2_x), .req_p2_y(req_p2_y), .req_p3_x(req_p3_x), .req_p3_y(req_p3_y),
      .rsp_valid(rsp_valid),
      .rsp_box_min_x(rsp_box_min_x), .rsp_box_min_y(rsp_box_min_y),
      .rsp_box_max_x(rsp_box_max_x), .rsp_box_max_y(rsp_box_max_y)
   );

   // Curve value at t/2^24 in exact integers, truncated toward zero to Q16.16.
   function automatic longint curve_value(longint p [4], longint t);
      logic signed [191:0] u, v, num, q;
      u = ONE_T - t;
      v = t;
      num = p[0]*u*u*u + 3*p[1]*u*u*v + 3*p[2]*u*v*v + p[3]*v*v*v;
      q = num >>> 72;
      if (num < 0 && (num & ((192'sd1 << 72) - 1)) != 0)
         q = q + 1;
      return longint'(q);
   endfunction

   function automatic void grow(longint p [4], longint t, inout longint lo, inout longint hi);
      longint v;
      if (t <= 0 || t >= ONE_T)
         return;
      v = curve_value(p, t);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
   endfunction

   function automatic logic [127:0] floor_sqrt(logic [127:0] x);
      logic [127:0] r, c;
      r = 0;
      for (int k = 59; k >= 0; k--) begin
         c = r | (128'd1 << k);
         if (c * c <= x)
            r = c;
      end
      return r;
   endfunction

   // Extend one axis by the interior extrema of its derivative quadratic.
   function automatic void axis_extrema(longint p [4], inout longint lo, inout longint hi);
      longint a, b, c, s, q2;
      logic signed [127:0] disc, n, t;
      a = -p[0] + 3*p[1] - 3*p[2] + p[3];
      b = 2 * (p[0] - 2*p[1] + p[2]);
      c = p[1] - p[0];
      if (a == 0) begin
         if (b != 0) begin
            t = (128'(-c) * ONE_T) / 128'(b);
            grow(p, longint'(t), lo, hi);
         end
         return;
      end
      disc = 128'(b) * 128'(b) - 4 * 128'(a) * 128'(c);
      if (disc < 0)
         return;
      s = longint'(floor_sqrt(disc << 48));
      q2 = -(b * ONE_T + (b >= 0 ? s : -s));
      if (q2 == 0)
         return;
      grow(p, q2 / (2 * a), lo, hi);
      if (c != 0 && ((c > 0) == (q2 > 0))) begin
         n = 128'(c < 0 ? -c : c) * 2 * ONE_T;
         t = 128'(q2 < 0 ? -q2 : q2);
         if (n < t)
            grow(p, longint'((n << 24) / t), lo, hi);
      end
   endfunction

   function automatic box_type bound_segment(segment_type sg);
      longint px [4], py [4], lox, hix, loy, hiy;
      box_type bx;
      for (int k = 0; k < 4; k++) begin
         px[k] = sg.px[k];
         py[k] = sg.py[k];
      end
      lox = px[0] < px[3] ? px[0] : px[3];
      hix = px[0] < px[3] ? px[3] : px[0];
      loy = py[0] < py[3] ? py[0] : py[3];
      hiy = py[0] < py[3] ? py[3] : py[0];
      if (sg.cubic) begin
         axis_extrema(px, lox, hix);
         axis_extrema(py, loy, hiy);
      end
      bx.min_x = cbb_pkg::coord_type'(lox);
      bx.min_y = cbb_pkg::coord_type'(loy);
      bx.max_x = cbb_pkg::coord_type'(hix);
      bx.max_y = cbb_pkg::coord_type'(hiy);
      return bx;
   endfunction

   function automatic cbb_pkg::coord_type rand_coord(int mode);
      case (mode)
         0: return cbb_pkg::coord_type'($urandom);
         1: return cbb_pkg::coord_type'($urandom_range(0, 2000)) - 1000;
         2: return cbb_pkg::coord_type'(int'($urandom_range(0, 32'h00FF_FFFF))
                                        - 32'sh0080_0000);
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                              : 32'sh8000_0000 + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic add_segment(logic cb, cbb_pkg::coord_type x [4],
                              cbb_pkg::coord_type y [4]);
      segment_type sg;
      sg.cubic = cb;
      sg.px = x;
      sg.py = y;
      seg_queue = {seg_queue, sg};
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      cbb_pkg::coord_type x [4], y [4];
      cbb_pkg::coord_type mx, mn;
      int mode;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      // Directed: extremes, lines with ignored controls, degenerate axes,
      // negative discriminant, zero q and interior extrema.
      x = '{mn, mx, mn, mx}; y = '{mx, mn, mx, mn}; add_segment(1, x, y);
      x = '{mn, mx, mn, mx}; y = '{mx, mn, mx, mn}; add_segment(0, x, y);
      x = '{mx, mn, mx, mn}; y = '{mn, mn, mn, mn}; add_segment(1, x, y);
      x = '{mx, mx, mx, mx}; y = '{mx, mx, mx, mx}; add_segment(1, x, y);
      x = '{0, 0, 0, 0};     y = '{0, 0, 0, 0};     add_segment(1, x, y);
      x = '{0, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000};
      y = '{0, 32'sh3_0000, 32'sh3_0000, 0};        add_segment(1, x, y);
      x = '{0, 32'sh4_0000, 32'sh4_0000, 0};
      y = '{0, 32'sh1_0000, 32'sh1_0000, 0};        add_segment(1, x, y);
      x = '{0, 32'sh1_0000, 0, 32'sh1_0000};
      y = '{0, 32'sh8_0000, -32'sh8_0000, 0};       add_segment(1, x, y);
      x = '{0, 1, 2, 3};     y = '{5, 5, 5, 5};     add_segment(1, x, y);
      x = '{0, 0, 32'sh1_0000, 32'sh1_0000};
      y = '{0, 32'sh1_0000, 0, 32'sh1_0000};        add_segment(1, x, y);
      x = '{-5, 7, -9, 3};   y = '{mn, 0, 0, mx};   add_segment(1, x, y);
      x = '{mx, 0, 0, mn};   y = '{1, -1, 1, -1};   add_segment(0, x, y);
      x = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA};
      y = '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555};
      add_segment(1, x, y);
      for (int i = 0; i < 1000; i++) begin
         mode = $urandom_range(0, 3);
         for (int k = 0; k < 4; k++) begin
            x[k] = rand_coord($urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : mode);
            y[k] = rand_coord($urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : mode);
         end
         add_segment($urandom_range(0, 4) != 0, x, y);
      end
   end

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            box_queue = {box_queue, bound_segment(seg_queue.pop_front())};
         if (seg_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            start        <= 1'b1;
            req_is_cubic <= seg_queue[0].cubic;
            req_p0_x <= seg_queue[0].px[0]; req_p0_y <= seg_queue[0].py[0];
            req_p1_x <= seg_queue[0].px[1]; req_p1_y <= seg_queue[0].py[1];
            req_p2_x <= seg_queue[0].px[2]; req_p2_y <= seg_queue[0].py[2];
            req_p3_x <= seg_queue[0].px[3]; req_p3_y <= seg_queue[0].py[3];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      box_type want;
      if (!reset && rsp_valid) begin
         if (box_queue.size() == 0) begin
            $display("%0t: unexpected box %h %h %h %h", $realtime, rsp_box_min_x,
                     rsp_box_min_y, rsp_box_max_x, rsp_box_max_y);
            errors++;
         end else begin
            want = box_queue.pop_front();
            if (rsp_box_min_x !== want.min_x) begin
               $display("%0t: min_x expected %h actual %h", $realtime, want.min_x, rsp_box_min_x);
               errors++;
            end
            if (rsp_box_min_y !== want.min_y) begin
               $display("%0t: min_y expected %h actual %h", $realtime, want.min_y, rsp_box_min_y);
               errors++;
            end
            if (rsp_box_max_x !== want.max_x) begin
               $display("%0t: max_x expected %h actual %h", $realtime, want.max_x, rsp_box_max_x);
               errors++;
            end
            if (rsp_box_max_y !== want.max_y) begin
               $display("%0t: max_y expected %h actual %h", $realtime, want.max_y, rsp_box_max_y);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_CAP)
         timed_out <= 1'b1;
   end

   initial begin
      reset = 1; idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      fork
         begin
            // Sender idling phases of random length.
            while (seg_queue.size() > 0) begin
               case ($urandom_range(0, 3))
                  0: idle_pct = 0;
                  1: idle_pct = 56;
                  2: idle_pct = 34;
                  default: idle_pct = 0;
               endcase
               repeat ($urandom_range(20, 200)) @(posedge clock);
            end
            while (start || box_queue.size() > 0) @(posedge clock);
            repeat (DRAIN_CYC) @(posedge clock);
         end
         wait (timed_out);
      join_any
      if (timed_out) begin
         $display("cubic_bezier_bounding_box test failed");
      end else if (errors == 0) begin
         $display("cubic_bezier_bounding_box test passed");
      end else begin
         $display("cubic_bezier_bounding_box test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/cbb_pkg.sv
rtl/cbb_div.sv
rtl/cbb_eval.sv
rtl/cubic_bezier_bounding_box.sv
dv/cubic_bezier_bounding_box_tb.sv
